@@ design/wavhp_pkg.sv @@
package wavhp_pkg;

    // Chunk identifiers as they sit in the shift register after their fourth byte.
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_FACT = 32'h7463_6166;

    // Byte positions of the last byte of each header field.
    localparam logic [15:0] POS_RIFF_ID   = 16'd3;
    localparam logic [15:0] POS_RIFF_SIZE = 16'd7;
    localparam logic [15:0] POS_WAVE_ID   = 16'd11;
    localparam logic [15:0] POS_FMT_ID    = 16'd15;
    localparam logic [15:0] POS_FMT_SIZE  = 16'd19;
    localparam logic [15:0] POS_TAG       = 16'd21;
    localparam logic [15:0] POS_CHANNELS  = 16'd23;
    localparam logic [15:0] POS_RATE      = 16'd27;
    localparam logic [15:0] POS_BYTE_RATE = 16'd31;
    localparam logic [15:0] POS_ALIGN     = 16'd33;
    localparam logic [15:0] POS_BITS      = 16'd35;
    localparam logic [15:0] POS_EXTRA     = 16'd37;
    localparam logic [15:0] POS_FACT_ID   = 16'd41;
    localparam logic [15:0] POS_FACT_SIZE = 16'd45;

    localparam logic [15:0] PLAIN_HDR_END = 16'd36;
    localparam logic [15:0] FACT_HDR_END  = 16'd46;
    localparam logic [15:0] DATA_ID_RESET = 16'd36;
    localparam logic [15:0] DATA_LAST_OFS = 16'd7;
    localparam logic [15:0] DATA_HDR_LEN  = 16'd8;
    localparam logic [31:0] PCM_FMT_SIZE  = 32'h10;
    localparam logic [15:0] PCM_TAG       = 16'd1;
    localparam logic [15:0] PCM_BITS      = 16'd16;
    // Largest fact size for which 46 + size + 8 still fits in 16 bits.
    localparam logic [31:0] FACT_SIZE_MAX = 32'd65481;

    localparam int TDATA_BITS = 184;

    typedef enum logic [3:0] {
        ST_VALID    = 4'd0,
        ST_RIFF_ID  = 4'd1,
        ST_WAVE_ID  = 4'd2,
        ST_FMT_ID   = 4'd3,
        ST_TAG      = 4'd4,
        ST_BITS     = 4'd5,
        ST_EXTRA    = 4'd6,
        ST_FACT_ID  = 4'd7,
        ST_TOO_LONG = 4'd8
    } status_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       start_of_file;
    } in_item_t;

    typedef struct packed {
        logic [31:0] data_size;
        logic [15:0] block_align;
        logic [31:0] byte_rate;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [31:0] riff_size;
        logic [15:0] header_length;
        status_t     status;
    } result_t;

endpackage

@@ design/wav_header_parser_unit.sv @@
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_tvalid/s_tready  | s_tdata[7:0] file byte, s_tuser start of file
// m_      | out       | m_tvalid/m_tready  | m_tdata status, length and captured fields
//
// One byte can be accepted in every cycle. A byte is parsed while it sits in the
// input register, and its result, if any, is in the output register at the next edge.
// Reset (aresetn low, synchronous) leaves the parser finished: bytes are
// dropped until one arrives with start of file set.
// While a result waits on m_tready, no byte is parsed; the input register still
// takes one byte if it is empty and then holds s_tready low.
module wav_header_parser_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] file_byte
    input  logic         s_tuser,   // [0] start_of_file
    output logic         m_tvalid,
    input  logic         m_tready,
    // [3:0] status, [19:4] header_length, [51:20] riff_size,
    // [67:52] channel_count, [99:68] sample_rate, [131:100] byte_rate,
    // [147:132] block_align, [179:148] data_size, [183:180] zero
    output logic [wavhp_pkg::TDATA_BITS-1:0] m_tdata
);
    import wavhp_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     load_ok;
    logic     fire;
    logic     emit;
    result_t  result;

    assign s_item.file_byte     = s_tdata;
    assign s_item.start_of_file = s_tuser;

    // A buffered byte is parsed only when the output register can take its result.
    assign fire = item_valid && load_ok;

    wavhp_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (load_ok),
        .item_valid (item_valid),
        .item       (item)
    );

    wavhp_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .emit    (emit),
        .result  (result)
    );

    wavhp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .result   (result),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ design/wavhp_in_reg.sv @@
module wavhp_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  wavhp_pkg::in_item_t s_item,
    input  logic               take,
    output logic               item_valid,
    output wavhp_pkg::in_item_t item
);
    import wavhp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    // The stage empties whenever the parser takes its item, so a new one may land then.
    assign s_tready = !valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ design/wavhp_parse.sv @@
module wavhp_parse (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  wavhp_pkg::in_item_t item,
    output logic                emit,
    output wavhp_pkg::result_t  result
);
    import wavhp_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic        fact_reg, fact_next;
    logic [15:0] data_ofs_reg, data_ofs_next;
    logic        fin_reg, fin_next;
    logic [31:0] riff_reg, riff_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;

    logic [15:0] p;
    logic [31:0] w;
    logic [15:0] half;
    logic        in_hdr;
    logic        active;
    status_t     status;

    always_comb begin
        // Start of file clears the per-file state before this byte is applied.
        if (item.start_of_file) begin
            p = '0;  fact_next = 1'b0;  data_ofs_next = DATA_ID_RESET;
            riff_next = '0;  chan_next = '0;  rate_next = '0;
            brate_next = '0;  align_next = '0;
            w = {item.file_byte, 24'd0};
        end else begin
            p = pos_reg;  fact_next = fact_reg;  data_ofs_next = data_ofs_reg;
            riff_next = riff_reg;  chan_next = chan_reg;  rate_next = rate_reg;
            brate_next = brate_reg;  align_next = align_reg;
            w = {item.file_byte, shift_reg[31:8]};
        end
        half   = w[31:16];
        active = fire && (item.start_of_file || !fin_reg);
        in_hdr = (p < PLAIN_HDR_END) || (fact_reg && !item.start_of_file && p < FACT_HDR_END);
        emit   = 1'b0;
        status = ST_VALID;

        if (in_hdr) begin
            unique case (p)
                POS_RIFF_ID:   if (w != ID_RIFF) begin emit = 1'b1; status = ST_RIFF_ID; end
                POS_RIFF_SIZE: riff_next = w;
                POS_WAVE_ID:   if (w != ID_WAVE) begin emit = 1'b1; status = ST_WAVE_ID; end
                POS_FMT_ID:    if (w != ID_FMT) begin emit = 1'b1; status = ST_FMT_ID; end
                POS_FMT_SIZE:  fact_next = (w != PCM_FMT_SIZE);
                POS_TAG:       if (half != PCM_TAG) begin emit = 1'b1; status = ST_TAG; end
                POS_CHANNELS:  chan_next = half;
                POS_RATE:      rate_next = w;
                POS_BYTE_RATE: brate_next = w;
                POS_ALIGN:     align_next = half;
                POS_BITS:      if (half != PCM_BITS) begin emit = 1'b1; status = ST_BITS; end
                POS_EXTRA:     if (half != 16'd0) begin emit = 1'b1; status = ST_EXTRA; end
                POS_FACT_ID:   if (w != ID_FACT) begin emit = 1'b1; status = ST_FACT_ID; end
                POS_FACT_SIZE: begin
                    if (w > FACT_SIZE_MAX) begin
                        emit   = 1'b1;
                        status = ST_TOO_LONG;
                    end else begin
                        data_ofs_next = FACT_HDR_END + w[15:0];
                    end
                end
                default: ;
            endcase
        end else if (p == data_ofs_next + DATA_LAST_OFS) begin
            emit = 1'b1;
        end

        emit       = emit && active;
        pos_next   = p + 16'd1;
        shift_next = w;
        fin_next   = emit ? 1'b1 : (item.start_of_file ? 1'b0 : fin_reg);

        result.status        = status;
        result.header_length = (status == ST_VALID) ? data_ofs_next + DATA_HDR_LEN : 16'd0;
        result.riff_size     = riff_next;
        result.channel_count = chan_next;
        result.sample_rate   = rate_next;
        result.byte_rate     = brate_next;
        result.block_align   = align_next;
        result.data_size     = (status == ST_VALID) ? w : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            shift_reg    <= '0;
            fact_reg     <= 1'b0;
            data_ofs_reg <= DATA_ID_RESET;
            fin_reg      <= 1'b1;
            riff_reg     <= '0;
            chan_reg     <= '0;
            rate_reg     <= '0;
            brate_reg    <= '0;
            align_reg    <= '0;
        end else if (active) begin
            pos_reg      <= pos_next;
            shift_reg    <= shift_next;
            fact_reg     <= fact_next;
            data_ofs_reg <= data_ofs_next;
            fin_reg      <= fin_next;
            riff_reg     <= riff_next;
            chan_reg     <= chan_next;
            rate_reg     <= rate_next;
            brate_reg    <= brate_next;
            align_reg    <= align_next;
        end
    end

endmodule

@@ design/wavhp_out_reg.sv @@
module wavhp_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                emit,
    input  wavhp_pkg::result_t  result,
    output logic                load_ok,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [wavhp_pkg::TDATA_BITS-1:0] m_tdata
);
    import wavhp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // The register may be refilled when empty or when its transaction completes.
    assign load_ok = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load_ok) begin
            valid_next = emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ok && emit) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(TDATA_BITS - $bits(result_t)){1'b0}}, data_reg};

endmodule
